@@ hw/rtl/lapd_pkg.sv @@
// ----------------------------------------------------------------------------
// lapd_pkg
// Types, constants and codes shared by the predictor decoder modules.
// ----------------------------------------------------------------------------
package lapd_pkg;

	localparam int MAX_CHANNELS   = 8;
	localparam int MAX_ORDER      = 32;
	localparam int MAX_MEANS      = 8;
	localparam int COEF_FRAC_BITS = 5;

	localparam int CH_W    = $clog2(MAX_CHANNELS);
	localparam int CHC_W   = $clog2(MAX_CHANNELS + 1);
	localparam int ORD_W   = $clog2(MAX_ORDER);
	localparam int ORDC_W  = $clog2(MAX_ORDER + 1);
	localparam int MEAN_W  = $clog2(MAX_MEANS);
	localparam int MCNT_W  = $clog2(MAX_MEANS + 1);
	localparam int HIST_D  = MAX_CHANNELS * MAX_ORDER;
	localparam int HADDR_W = CH_W + ORD_W;
	localparam int MEAN_D  = MAX_CHANNELS * MAX_MEANS;
	localparam int MADDR_W = CH_W + MEAN_W;
	localparam int OSUM_W  = 32 + MEAN_W + 1;
	localparam int DIV_W   = 49;
	localparam int DVS_W   = 16;
	localparam int DCNT_W  = $clog2(DIV_W + 1);

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_COEF  = 2'd1;
	localparam logic [1:0] OP_RESID = 2'd2;
	localparam logic [1:0] OP_SHIFT = 2'd3;

	localparam logic [2:0] PRED_ZERO  = 3'd0;
	localparam logic [2:0] PRED_MEAN  = 3'd1;
	localparam logic [2:0] PRED_DIFF1 = 3'd2;
	localparam logic [2:0] PRED_DIFF2 = 3'd3;
	localparam logic [2:0] PRED_DIFF3 = 3'd4;
	localparam logic [2:0] PRED_LPC   = 3'd5;

	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_MEANS    = 2'd1;
	localparam logic [1:0] REG_INIT     = 2'd2;
	localparam logic [1:0] REG_CHANNELS = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  pred;
		logic [ORDC_W-1:0] order;
		logic [31:0] value;
		logic [5:0]  shift;
		logic        last;
	} item_t;

	typedef struct packed {
		logic        format_v2;
		logic [3:0]  mean_blocks;
		logic [15:0] initial_mean;
		logic [3:0]  num_channels;
		logic        mean_fill;
	} cfg_t;

endpackage

@@ hw/rtl/lossless_audio_predictor_decoder.sv @@
// ----------------------------------------------------------------------------
// lossless_audio_predictor_decoder
// Rebuilds audio samples from decoded residuals, block by block.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready: start block, load coefficient,
// residual or set bit shift. Each residual yields one sample on
// out_valid/out_ready, tagged with its channel and the block-end flag.
// Registers sit on an APB port; pready is always high, and they are to be
// written only while no request is in flight.
// A two-entry queue parts the input handshake from the execution unit.
// A residual walks its history taps (LPC order, or 1 to 3 for the fixed
// differences) through the single pipelined MAC. When means are averaged,
// a block start spends most of its time in the bit-serial divider, and a
// block end adds a mean update that runs through the same divider.
// After reset all history reads as zero and all stored means read as
// initial_mean; no clearing pass is needed. When the receiver stalls, the
// held sample waits in the output register and execution stops at the
// next sample, while the queue still takes up to two requests.
// ----------------------------------------------------------------------------
module lossless_audio_predictor_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [2:0]         predictor,
	input  logic [5:0]         order,
	input  logic signed [31:0] value,
	input  logic [5:0]         shift_amount,
	input  logic               block_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sample,
	output logic [2:0]         sample_channel,
	output logic               last_of_block,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic            v2_q;
	logic [3:0]      mb_q, nc_q;
	logic [15:0]     im_q;
	logic            fill_q;
	logic            wr;
	lapd_pkg::cfg_t  cfg;
	lapd_pkg::item_t q_item;
	logic            q_valid, q_pop;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q   <= 1'b1;
			mb_q   <= 4'd4;
			im_q   <= 16'd0;
			nc_q   <= 4'd1;
			fill_q <= 1'b0;
		end else begin
			fill_q <= 1'b0;
			if (wr) begin
				case (paddr[3:2])
					lapd_pkg::REG_FORMAT: v2_q <= pwdata[0];
					lapd_pkg::REG_MEANS:  mb_q <= pwdata[3:0];
					lapd_pkg::REG_INIT: begin
						im_q   <= pwdata[15:0];
						fill_q <= 1'b1;
					end
					default: nc_q <= pwdata[3:0];
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[3:2])
			lapd_pkg::REG_FORMAT: prdata = {31'd0, v2_q};
			lapd_pkg::REG_MEANS:  prdata = {28'd0, mb_q};
			lapd_pkg::REG_INIT:   prdata = {16'd0, im_q};
			default:              prdata = {28'd0, nc_q};
		endcase
	end

	assign cfg.format_v2    = v2_q;
	assign cfg.mean_blocks  = mb_q;
	assign cfg.initial_mean = im_q;
	assign cfg.num_channels = nc_q;
	assign cfg.mean_fill    = fill_q;

	lapd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .predictor(predictor), .order(order), .value(value),
		.shift_amount(shift_amount), .block_end(block_end),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	lapd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
		.sample(sample), .sample_channel(sample_channel),
		.last_of_block(last_of_block)
	);

endmodule

@@ hw/rtl/lapd_ram.sv @@
// ----------------------------------------------------------------------------
// lapd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lapd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/lapd_front.sv @@
// ----------------------------------------------------------------------------
// lapd_front
// Accepts input requests, normalizes predictor and order, and queues them.
// ----------------------------------------------------------------------------
module lapd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic [2:0]           predictor,
	input  logic [5:0]           order,
	input  logic signed [31:0]   value,
	input  logic [5:0]           shift_amount,
	input  logic                 block_end,
	output logic                 q_valid,
	output lapd_pkg::item_t      q_item,
	input  logic                 q_pop
);

	lapd_pkg::item_t ent_q [2];
	lapd_pkg::item_t cls;
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		cls.op    = op;
		// Unused predictor codes decode as the zero predictor.
		cls.pred  = (predictor > lapd_pkg::PRED_LPC) ? lapd_pkg::PRED_ZERO : predictor;
		cls.order = (order > 6'(lapd_pkg::MAX_ORDER)) ?
			lapd_pkg::ORDC_W'(lapd_pkg::MAX_ORDER) : lapd_pkg::ORDC_W'(order);
		cls.value = value;
		cls.shift = shift_amount;
		cls.last  = block_end;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ hw/rtl/lapd_div.sv @@
// ----------------------------------------------------------------------------
// lapd_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module lapd_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [lapd_pkg::DIV_W-1:0]    dividend,
	input  logic [lapd_pkg::DVS_W-1:0]           divisor,
	output logic                                 done,
	output logic signed [lapd_pkg::DIV_W-1:0]    quotient
);

	logic                              busy_q, done_q, neg_q;
	logic [lapd_pkg::DCNT_W-1:0]       cnt_q;
	logic [lapd_pkg::DIV_W-1:0]        mag_q;
	logic [lapd_pkg::DVS_W-1:0]        rem_q, dvs_q;
	logic [lapd_pkg::DVS_W:0]          trial;
	logic                              qbit;

	assign trial    = {rem_q, mag_q[lapd_pkg::DIV_W-1]};
	assign qbit     = (trial >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(mag_q) : $signed(mag_q);

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[lapd_pkg::DIV_W-1];
			mag_q <= dividend[lapd_pkg::DIV_W-1] ? 49'(-dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[lapd_pkg::DIV_W-2:0], qbit};
			rem_q <= qbit ? lapd_pkg::DVS_W'(trial - {1'b0, dvs_q}) :
				trial[lapd_pkg::DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lapd_pkg::DCNT_W'(lapd_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ hw/rtl/lapd_back.sv @@
// ----------------------------------------------------------------------------
// lapd_back
// Executes queued requests: block setup, coefficient loads, bit shift settings,
// sample reconstruction on a pipelined MAC, and the per-channel mean updates.
// ----------------------------------------------------------------------------
module lapd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lapd_pkg::cfg_t      cfg,
	input  logic                q_valid,
	input  lapd_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  sample,
	output logic [2:0]          sample_channel,
	output logic                last_of_block
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OFS  = 4'd1;
	localparam logic [3:0] S_ODIV = 4'd2;
	localparam logic [3:0] S_TAP  = 4'd3;
	localparam logic [3:0] S_FIN  = 4'd4;
	localparam logic [3:0] S_MST  = 4'd5;
	localparam logic [3:0] S_MDIV = 4'd6;
	localparam logic [3:0] S_MSH  = 4'd7;
	localparam logic [3:0] S_MWR  = 4'd8;

	localparam int CW = lapd_pkg::CH_W;
	localparam int OW = lapd_pkg::ORD_W;
	localparam int OC = lapd_pkg::ORDC_W;
	localparam int MW = lapd_pkg::MEAN_W;
	localparam int MC = lapd_pkg::MCNT_W;
	localparam int CHC_LIM_W = lapd_pkg::CHC_W;
	localparam int DIVW = lapd_pkg::DIV_W;

	logic [3:0]         st_q;
	logic [CW-1:0]      ch_q;
	logic [2:0]         pred_q;
	logic [OC-1:0]      order_q;
	logic [5:0]         ccnt_q;
	logic [31:0]        ofs_q;
	logic [5:0]         bs_q;
	logic [47:0]        sum_q;
	logic [15:0]        cnt_q;
	logic [OW-1:0]      hd_q [lapd_pkg::MAX_CHANNELS];
	logic [lapd_pkg::HIST_D-1:0] hv_q;
	logic [lapd_pkg::MEAN_D-1:0] mv_q;
	logic [OC-1:0]      iss_q;
	logic [OC-1:0]      tapn_q;
	logic [31:0]        res_q;
	logic               last_q;
	logic [31:0]        h1_q, h2_q, h3_q;
	logic [63:0]        acc_q;
	logic [lapd_pkg::OSUM_W-1:0] osum_q;
	logic [31:0]        m_q;

	logic               hv_s1, mv_s1, r1_v_s1, p1_v_s1, p2_v_s2, p3_v_s3;
	logic [MW-1:0]      r1_i_s1;
	logic [1:0]         p1_j_s1;
	logic               p1_fx_s1;
	logic [31:0]        diff_s2, cf_s2;
	logic [63:0]        prod_s3;

	logic               out_valid_q, last_out_q;
	logic [31:0]        smp_out_q;
	logic [CW-1:0]      chan_out_q;

	logic [MC-1:0]      n_mean, ofs_n;
	logic [OW-1:0]      hd_cur;
	logic [lapd_pkg::HADDR_W-1:0] h_raddr, h_waddr;
	logic [lapd_pkg::MADDR_W-1:0] m_raddr, m_waddr;
	logic [31:0]        hrd, crd, mrd, hdat, mean_rd, m_wdata, smp;
	logic               h_issue, m_issue, h_we, m_we, c_we, out_ok;
	logic               ofs_done, tap_done, msh_done;
	logic               div_start, div_done;
	logic signed [lapd_pkg::DIV_W-1:0] div_dnd, div_q;
	logic [lapd_pkg::DVS_W-1:0] div_dvs;
	logic [15:0]        cnt_eff;
	logic [CHC_LIM_W-1:0] lim;
	logic [CW-1:0]      ch_next;
	logic [47:0]        nsum;
	logic [15:0]        ncnt;
	logic [63:0]        ofs_wide;
	logic [31:0]        m_adj;

	assign n_mean = (cfg.mean_blocks > 4'(lapd_pkg::MAX_MEANS)) ?
		MC'(lapd_pkg::MAX_MEANS) : MC'(cfg.mean_blocks);
	assign ofs_n  = (n_mean == '0) ? MC'(1) : n_mean;
	assign hd_cur = hd_q[ch_q];

	assign h_issue = (st_q == S_TAP) && (iss_q < tapn_q);
	assign m_issue = ((st_q == S_OFS) && (iss_q < OC'(ofs_n))) ||
		((st_q == S_MSH) && (iss_q < OC'(n_mean)));
	assign h_raddr = {ch_q, OW'(hd_cur - OW'(1) - iss_q[OW-1:0])};
	assign m_raddr = {ch_q, iss_q[MW-1:0]};
	assign h_waddr = {ch_q, hd_cur};
	assign hdat    = hv_s1 ? hrd : 32'd0;
	assign mean_rd = mv_s1 ? mrd : {16'd0, cfg.initial_mean};

	assign ofs_done = (iss_q == OC'(ofs_n)) && !r1_v_s1;
	assign msh_done = (iss_q >= OC'(n_mean)) && !r1_v_s1;
	assign tap_done = (iss_q == tapn_q) && !p1_v_s1 && !p2_v_s2 && !p3_v_s3;

	assign out_ok = !out_valid_q || out_ready;
	assign h_we   = (st_q == S_FIN) && out_ok;
	assign c_we   = (st_q == S_IDLE) && q_valid && (q_item.op == lapd_pkg::OP_COEF) &&
		(ccnt_q < 6'(lapd_pkg::MAX_ORDER));
	assign q_pop  = (st_q == S_IDLE) && q_valid;

	assign m_we    = ((st_q == S_MSH) && r1_v_s1) || (st_q == S_MWR);
	assign m_waddr = (st_q == S_MWR) ? {ch_q, MW'(n_mean - MC'(1))} :
		{ch_q, MW'(r1_i_s1 - MW'(1))};
	assign m_wdata = (st_q == S_MWR) ? m_q : mean_rd;

	// Sample reconstruction for the predictor of the open block.
	always_comb begin
		case (pred_q)
			lapd_pkg::PRED_MEAN:  smp = res_q + ofs_q;
			lapd_pkg::PRED_DIFF1: smp = res_q + h1_q;
			lapd_pkg::PRED_DIFF2: smp = res_q + {h1_q[30:0], 1'b0} - h2_q;
			lapd_pkg::PRED_DIFF3: smp = res_q + 32'(3 * (h1_q - h2_q)) + h3_q;
			lapd_pkg::PRED_LPC:
				smp = res_q + acc_q[lapd_pkg::COEF_FRAC_BITS +: 32] + ofs_q;
			default: smp = 32'd0;
		endcase
	end

	assign nsum = sum_q + {{16{smp[31]}}, smp};
	assign ncnt = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

	assign cnt_eff = (cnt_q == 16'd0) ? 16'd1 : cnt_q;
	always_comb begin
		if (st_q == S_OFS) begin
			div_dnd = DIVW'($signed(osum_q)) +
				(cfg.format_v2 ? $signed({1'b0, 48'(n_mean >> 1)}) : '0);
			div_dvs = lapd_pkg::DVS_W'(n_mean);
		end else begin
			div_dnd = DIVW'($signed(sum_q)) +
				(cfg.format_v2 ? $signed({1'b0, 48'(cnt_eff >> 1)}) : '0);
			div_dvs = cnt_eff;
		end
	end

	assign div_start = ((st_q == S_OFS) && ofs_done && (n_mean != '0)) ||
		((st_q == S_MST) && (n_mean != '0));

	assign ofs_wide = 64'($signed(div_q)) >>> bs_q;
	assign m_adj    = !cfg.format_v2 ? div_q[31:0] :
		(bs_q[5] ? 32'd0 : (div_q[31:0] << bs_q[4:0]));

	assign lim = (cfg.num_channels == 4'd0) ? CHC_LIM_W'(1) :
		(cfg.num_channels > 4'(lapd_pkg::MAX_CHANNELS)) ?
		CHC_LIM_W'(lapd_pkg::MAX_CHANNELS) : CHC_LIM_W'(cfg.num_channels);
	assign ch_next = (CHC_LIM_W'(ch_q) + CHC_LIM_W'(1) >= lim) ? '0 : CW'(ch_q + 1'b1);

	lapd_ram #(.WIDTH(32), .DEPTH(lapd_pkg::HIST_D)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(smp),
		.raddr(h_raddr), .rdata(hrd)
	);

	lapd_ram #(.WIDTH(32), .DEPTH(lapd_pkg::MAX_ORDER)) u_coef (
		.clk(clk), .we(c_we), .waddr(ccnt_q[OW-1:0]), .wdata(q_item.value),
		.raddr(iss_q[OW-1:0]), .rdata(crd)
	);

	lapd_ram #(.WIDTH(32), .DEPTH(lapd_pkg::MEAN_D)) u_mean (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(mrd)
	);

	lapd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dnd),
		.divisor(div_dvs), .done(div_done), .quotient(div_q)
	);

	// MAC datapath and read-side pipeline registers.
	always_ff @(posedge clk) begin
		hv_s1    <= hv_q[h_raddr];
		mv_s1    <= mv_q[m_raddr];
		r1_i_s1  <= iss_q[MW-1:0];
		p1_j_s1  <= iss_q[1:0];
		p1_fx_s1 <= (iss_q < OC'(3));
		diff_s2  <= hdat - ofs_q;
		cf_s2    <= crd;
		prod_s3  <= 64'($signed(cf_s2) * $signed(diff_s2));
		if (p1_v_s1 && p1_fx_s1) begin
			case (p1_j_s1)
				2'd0:    h1_q <= hdat;
				2'd1:    h2_q <= hdat;
				default: h3_q <= hdat;
			endcase
		end
		if (h_we) begin
			smp_out_q  <= smp;
			chan_out_q <= ch_q;
			last_out_q <= last_q;
		end
		if (st_q == S_MDIV && div_done) begin
			m_q <= m_adj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ch_q        <= '0;
			pred_q      <= lapd_pkg::PRED_ZERO;
			order_q     <= '0;
			ccnt_q      <= '0;
			ofs_q       <= '0;
			bs_q        <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			hd_q        <= '{default: '0};
			hv_q        <= '0;
			mv_q        <= '0;
			iss_q       <= '0;
			tapn_q      <= '0;
			res_q       <= '0;
			last_q      <= 1'b0;
			acc_q       <= '0;
			osum_q      <= '0;
			r1_v_s1     <= 1'b0;
			p1_v_s1     <= 1'b0;
			p2_v_s2     <= 1'b0;
			p3_v_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			r1_v_s1 <= m_issue;
			p1_v_s1 <= h_issue;
			p2_v_s2 <= p1_v_s1;
			p3_v_s3 <= p2_v_s2;
			if (h_issue || m_issue) begin
				iss_q <= iss_q + 1'b1;
			end
			if (p3_v_s3) begin
				acc_q <= acc_q + prod_s3;
			end
			if (cfg.mean_fill) begin
				mv_q <= '0;
			end else if (m_we) begin
				mv_q[m_waddr] <= 1'b1;
			end
			if (h_we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						case (q_item.op)
							lapd_pkg::OP_START: begin
								pred_q  <= q_item.pred;
								order_q <= q_item.order;
								ccnt_q  <= '0;
								sum_q   <= '0;
								cnt_q   <= '0;
								osum_q  <= '0;
								iss_q   <= '0;
								st_q    <= S_OFS;
							end
							lapd_pkg::OP_COEF: begin
								if (ccnt_q != 6'd63) begin
									ccnt_q <= ccnt_q + 6'd1;
								end
							end
							lapd_pkg::OP_SHIFT: begin
								bs_q <= q_item.shift;
							end
							default: begin
								res_q  <= q_item.value;
								last_q <= q_item.last;
								iss_q  <= '0;
								acc_q  <= cfg.format_v2 ?
									(64'd1 << lapd_pkg::COEF_FRAC_BITS) : 64'd0;
								case (pred_q)
									lapd_pkg::PRED_DIFF1: tapn_q <= OC'(1);
									lapd_pkg::PRED_DIFF2: tapn_q <= OC'(2);
									lapd_pkg::PRED_DIFF3: tapn_q <= OC'(3);
									lapd_pkg::PRED_LPC:   tapn_q <= order_q;
									default:              tapn_q <= '0;
								endcase
								st_q <= S_TAP;
							end
						endcase
					end
				end
				S_OFS: begin
					if (r1_v_s1) begin
						osum_q <= osum_q + lapd_pkg::OSUM_W'($signed(mean_rd));
					end
					if (ofs_done) begin
						if (n_mean == '0) begin
							// With no means averaged, entry zero is the offset.
							ofs_q <= osum_q[31:0];
							st_q  <= S_IDLE;
						end else begin
							st_q <= S_ODIV;
						end
					end
				end
				S_ODIV: begin
					if (div_done) begin
						ofs_q <= cfg.format_v2 ? ofs_wide[31:0] : div_q[31:0];
						st_q  <= S_IDLE;
					end
				end
				S_TAP: begin
					if (tap_done) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_ok) begin
						hd_q[ch_q]      <= hd_cur + OW'(1);
						hv_q[h_waddr]   <= 1'b1;
						sum_q           <= nsum;
						cnt_q           <= ncnt;
						st_q            <= last_q ? S_MST : S_IDLE;
					end
				end
				S_MST: begin
					if (n_mean == '0) begin
						sum_q <= '0;
						cnt_q <= '0;
						ch_q  <= ch_next;
						st_q  <= S_IDLE;
					end else begin
						st_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					if (div_done) begin
						iss_q <= OC'(1);
						st_q  <= S_MSH;
					end
				end
				S_MSH: begin
					if (msh_done) begin
						st_q <= S_MWR;
					end
				end
				S_MWR: begin
					sum_q <= '0;
					cnt_q <= '0;
					ch_q  <= ch_next;
					st_q  <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign sample         = smp_out_q;
	assign sample_channel = 3'(chan_out_q);
	assign last_of_block  = last_out_q;

endmodule

@@ bench/lossless_audio_predictor_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lossless_audio_predictor_decoder_tb
// Drives residual, block start, coefficient and bit shift requests through
// the decoder under random idling on both sides, rebuilds every sample with
// an in-bench predictor and compares each output sample field by field.
// ----------------------------------------------------------------------------
module lossless_audio_predictor_decoder_tb;
	import lapd_pkg::*;

	typedef struct {
		logic [1:0]  op;
		logic [2:0]  pred;
		logic [5:0]  ord;
		logic [31:0] val;
		logic [5:0]  sh;
		logic        last;
		logic        known;
		logic [31:0] known_sample;
	} script_row_t;

	typedef struct {
		logic [31:0] sample;
		logic [2:0]  channel;
		logic        last;
	} rebuilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_SHIFT;
	logic [2:0] predictor = '0;
	logic [5:0] order = '0;
	logic signed [31:0] value = '0;
	logic [5:0] shift_amount = '0;
	logic block_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] sample;
	logic [2:0] sample_channel;
	logic last_of_block;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lossless_audio_predictor_decoder DUT (.*);

	always #5 clk = ~clk;

	// Predictor state and register copies.
	logic [31:0] hist [MAX_CHANNELS][MAX_ORDER];
	logic [31:0] means [MAX_CHANNELS][MAX_MEANS];
	logic [31:0] coefs [MAX_ORDER];
	logic [2:0]  cur_ch, cur_pred;
	logic [5:0]  cur_ord, coef_cnt, bshift;
	logic [31:0] offset;
	logic [47:0] bsum;
	logic [15:0] bcnt;
	logic        cfg_v2;
	logic [3:0]  cfg_mb, cfg_nch;
	logic [15:0] cfg_init;

	rebuilt_t pending_samples [$];
	script_row_t script [$];
	int errors = 0;
	int sent = 0;
	bit calm = 0;
	logic        row_known = 1'b0;
	logic [31:0] row_known_sample = '0;

	function automatic void fill_means();
		for (int c = 0; c < MAX_CHANNELS; c++)
			for (int i = 0; i < MAX_MEANS; i++)
				means[c][i] = {16'd0, cfg_init};
	endfunction

	function automatic int means_used();
		return (cfg_mb > MAX_MEANS) ? MAX_MEANS : cfg_mb;
	endfunction

	function automatic logic [31:0] block_offset_of(int ch);
		int n;
		longint s;
		n = means_used();
		if (n == 0)
			return means[ch][0];
		s = cfg_v2 ? longint'(n / 2) : 0;
		for (int i = 0; i < n; i++)
			s += $signed(means[ch][i]);
		s = s / n;
		if (cfg_v2)
			s = s >>> bshift;
		return s[31:0];
	endfunction

	function automatic void store_block_mean(int ch);
		int n;
		longint s, cnt, q;
		n = means_used();
		if (n == 0)
			return;
		cnt = (bcnt != 0) ? longint'(bcnt) : 1;
		s = $signed(bsum);
		if (cfg_v2)
			s += cnt / 2;
		q = s / cnt;
		if (cfg_v2)
			q = q << bshift;
		for (int i = 1; i < n; i++)
			means[ch][i-1] = means[ch][i];
		means[ch][n-1] = q[31:0];
	endfunction

	function automatic logic [31:0] predicted_sample(int ch, logic [31:0] r);
		longint acc, sh;
		int d, c;
		case (cur_pred)
			PRED_MEAN:  return r + offset;
			PRED_DIFF1: return r + hist[ch][0];
			PRED_DIFF2: return r + 2 * hist[ch][0] - hist[ch][1];
			PRED_DIFF3: return r + 3 * (hist[ch][0] - hist[ch][1]) + hist[ch][2];
			PRED_LPC: begin
				acc = cfg_v2 ? (longint'(1) << COEF_FRAC_BITS) : 0;
				for (int j = 0; j < cur_ord; j++) begin
					d = hist[ch][j] - offset;
					c = coefs[j];
					acc += longint'(c) * longint'(d);
				end
				sh = acc >>> COEF_FRAC_BITS;
				return r + sh[31:0] + offset;
			end
			default: return 32'd0;
		endcase
	endfunction

	function automatic void apply_request(logic [1:0] o, logic [2:0] p, logic [5:0] od,
			logic [31:0] v, logic [5:0] s, logic l, logic kn, logic [31:0] ks);
		int ch, lim;
		logic [31:0] smp;
		rebuilt_t e;
		ch = cur_ch;
		case (o)
			OP_START: begin
				cur_pred = p;
				cur_ord = (od > MAX_ORDER) ? MAX_ORDER : od;
				coef_cnt = 0;
				offset = block_offset_of(ch);
				bsum = 0;
				bcnt = 0;
			end
			OP_COEF: begin
				if (coef_cnt < MAX_ORDER)
					coefs[coef_cnt] = v;
				if (coef_cnt < 63)
					coef_cnt++;
			end
			OP_SHIFT: bshift = s;
			default: begin
				smp = predicted_sample(ch, v);
				for (int k = MAX_ORDER - 1; k > 0; k--)
					hist[ch][k] = hist[ch][k-1];
				hist[ch][0] = smp;
				bsum = bsum + {{16{smp[31]}}, smp};
				if (bcnt != 16'hFFFF)
					bcnt++;
				e.sample = kn ? ks : smp;
				e.channel = ch[2:0];
				e.last = l;
				pending_samples.push_back(e);
				if (l) begin
					store_block_mean(ch);
					bsum = 0;
					bcnt = 0;
					lim = (cfg_nch == 0) ? 1 : ((cfg_nch > MAX_CHANNELS) ? MAX_CHANNELS : cfg_nch);
					cur_ch = (ch + 1 >= lim) ? 0 : ch + 1;
				end
			end
		endcase
	endfunction

	// Both handshakes are observed here; inputs move only on falling edges.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			apply_request(op, predictor, order, value, shift_amount, block_end,
				row_known, row_known_sample);
		if (out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				$error("unexpected sample %h", sample);
				errors++;
			end else begin
				rebuilt_t e;
				e = pending_samples.pop_front();
				if (sample !== e.sample) begin
					$error("sample: expected %h, got %h", e.sample, sample);
					errors++;
				end
				if (sample_channel !== e.channel) begin
					$error("sample_channel: expected %0d, got %0d", e.channel, sample_channel);
					errors++;
				end
				if (last_of_block !== e.last) begin
					$error("last_of_block: expected %0d, got %0d", e.last, last_of_block);
					errors++;
				end
			end
		end
	end

	// Receiver: a random stall before every sample, none while calm.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send(logic [1:0] o, logic [2:0] p, logic [5:0] od, logic [31:0] v,
			logic [5:0] s, logic l, logic kn = 1'b0, logic [31:0] ks = '0);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= o;
		predictor <= p;
		order <= od;
		value <= v;
		shift_amount <= s;
		block_end <= l;
		row_known = kn;
		row_known_sample = ks;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(negedge clk);
		// A block start or mean update may still be running with no sample due.
		repeat (200) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FORMAT:   cfg_v2 = data[0];
			REG_MEANS:    cfg_mb = data[3:0];
			REG_INIT: begin
				cfg_init = data[15:0];
				fill_means();
			end
			default:      cfg_nch = data[3:0];
		endcase
	endtask

	task automatic set_config(logic v2, logic [3:0] mb, logic [15:0] im, logic [3:0] nc);
		reg_write(REG_FORMAT, {31'd0, v2});
		reg_write(REG_MEANS, {28'd0, mb});
		reg_write(REG_INIT, {16'd0, im});
		reg_write(REG_CHANNELS, {28'd0, nc});
	endtask

	function automatic logic [31:0] rand_residual();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3: return $urandom();
			default: return $urandom_range(0, 4000) - 2000;
		endcase
	endfunction

	function automatic void add_row(logic [1:0] o, logic [2:0] p, logic [5:0] od,
			logic [31:0] v, logic [5:0] s, logic l, logic kn = 1'b0, logic [31:0] ks = '0);
		script_row_t r;
		r.op = o; r.pred = p; r.ord = od; r.val = v; r.sh = s; r.last = l;
		r.known = kn; r.known_sample = ks;
		script.push_back(r);
	endfunction

	task automatic random_phase(int target);
		int len, od, extra;
		logic [2:0] p;
		while (sent < target) begin
			if ($urandom_range(0, 99) < 15) begin
				send($urandom_range(0, 3), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom());
			end else begin
				if ($urandom_range(0, 4) == 0)
					send(OP_SHIFT, 0, 0, 0, $urandom_range(0, 9) == 0 ? $urandom() :
						$urandom_range(0, 8), 0);
				p = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
				od = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
				send(OP_START, p, od, $urandom(), $urandom(), $urandom());
				if (p == PRED_LPC) begin
					extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 0;
					for (int i = 0; i < od + extra && i < 40; i++)
						send(OP_COEF, 0, 0, ($urandom_range(0, 7) == 0) ? $urandom() :
							$urandom_range(0, 128) - 64, 0, 0);
				end
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 14) == 0)
						send(OP_SHIFT, 0, 0, 0, $urandom_range(0, 6), 0);
					send(OP_RESID, $urandom(), $urandom(), rand_residual(), $urandom(),
						i == len - 1);
				end
			end
		end
	endtask

	initial begin
		cfg_v2 = 1'b1; cfg_mb = 4; cfg_init = 0; cfg_nch = 1;
		for (int c = 0; c < MAX_CHANNELS; c++)
			for (int k = 0; k < MAX_ORDER; k++)
				hist[c][k] = '0;
		fill_means();
		cur_ch = 0; cur_pred = PRED_ZERO; cur_ord = 0; coef_cnt = 0;
		offset = 0; bshift = 0; bsum = 0; bcnt = 0;

		// Residual before any start, zero and unused predictors, wrapping diff1,
		// an abandoned block, bit shift changes inside blocks, a short LPC block.
		add_row(OP_RESID, PRED_LPC, 6'd63, 32'h7FFFFFFF, 6'd63, 1'b0, 1'b1, 32'd0);
		add_row(OP_START, PRED_ZERO, 6'd0, 32'd0, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'h80000000, 6'd0, 1'b1, 1'b1, 32'd0);
		add_row(OP_START, PRED_DIFF1, 6'd0, 32'd0, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'h7FFFFFFF, 6'd0, 1'b0, 1'b1, 32'h7FFFFFFF);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'd1, 6'd0, 1'b1, 1'b1, 32'h80000000);
		add_row(OP_START, 3'd7, 6'd0, 32'd0, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'd12345, 6'd0, 1'b1, 1'b1, 32'd0);
		add_row(OP_START, PRED_MEAN, 6'd0, 32'd0, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, -32'sd5, 6'd0, 1'b0);
		add_row(OP_START, PRED_DIFF2, 6'd0, 32'd0, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'd100, 6'd0, 1'b0);
		add_row(OP_SHIFT, PRED_ZERO, 6'd0, 32'd0, 6'd3, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'd200, 6'd0, 1'b1);
		add_row(OP_START, PRED_DIFF3, 6'd0, 32'd0, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'h80000000, 6'd0, 1'b0);
		add_row(OP_SHIFT, PRED_ZERO, 6'd0, 32'd0, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'hFFFFFFFF, 6'd0, 1'b1);
		add_row(OP_START, PRED_LPC, 6'd3, 32'd0, 6'd0, 1'b0);
		add_row(OP_COEF, PRED_ZERO, 6'd0, 32'd32, 6'd0, 1'b0);
		add_row(OP_COEF, PRED_ZERO, 6'd0, -32'sd32, 6'd0, 1'b0);
		add_row(OP_COEF, PRED_ZERO, 6'd0, 32'h7FFFFFFF, 6'd0, 1'b0);
		add_row(OP_COEF, PRED_ZERO, 6'd0, 32'h80000000, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, 32'd7, 6'd0, 1'b0);
		add_row(OP_RESID, PRED_ZERO, 6'd0, -32'sd7, 6'd0, 1'b1);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i])
			send(script[i].op, script[i].pred, script[i].ord, script[i].val, script[i].sh,
				script[i].last, script[i].known, script[i].known_sample);

		// Oversized order with two coefficients too many loads every coefficient.
		send(OP_START, PRED_LPC, 6'd63, 32'd0, 6'd0, 1'b0);
		for (int i = 0; i < MAX_ORDER + 2; i++)
			send(OP_COEF, 0, 0, $urandom_range(0, 64) - 32, 0, 0);
		for (int i = 0; i < 3; i++)
			send(OP_RESID, 0, 0, rand_residual(), 0, i == 2);

		random_phase(200);
		drain();
		set_config(1'b0, 4'd0, 16'd128, 4'd8);
		calm = 1;
		random_phase(380);
		calm = 0;
		drain();
		set_config(1'b1, 4'd8, 16'd32768, 4'd3);
		random_phase(560);
		drain();
		set_config(1'b0, 4'd15, 16'hFFFF, 4'd0);
		random_phase(740);
		drain();
		set_config(1'b1, 4'd1, 16'd0, 4'd15);
		random_phase(900);
		drain();
		set_config(1'b1, 4'd4, 16'd128, 4'd2);
		random_phase(1050);
		drain();

		if (errors == 0 && pending_samples.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (pending_samples.size() != 0)
				$error("%0d samples never arrived", pending_samples.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/lapd_pkg.sv
hw/rtl/lapd_ram.sv
hw/rtl/lapd_front.sv
hw/rtl/lapd_div.sv
hw/rtl/lapd_back.sv
hw/rtl/lossless_audio_predictor_decoder.sv
bench/lossless_audio_predictor_decoder_tb.sv
